// ===== rtl/tcca_pkg.sv =====
// Shared widths, codes and divider side-band type for the triangle cell coverage block.
`timescale 1ns / 1ps
package tcca_pkg;

   localparam int LEN_W = 16;
   localparam int COL_W = 11;
   localparam int ROW_W = 11;
   localparam int AREA_W = 32;
   localparam int KIND_W = 2;

   // Long division: 64 bit dividend, 33 bit divisor, quotient bounded to 34 bits.
   localparam int NUM_W = 64;
   localparam int DEN_W = 33;
   localparam int QUO_W = 34;

   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic sub_mode;
      logic [AREA_W-1:0] full;
   } side_type;

endpackage

// ===== rtl/tcca_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module tcca_div import tcca_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  side_type in_side,
   output logic out_valid,
   output logic [QUO_W-1:0] out_quo,
   output side_type out_side
);

   logic [DEN_W-1:0] rem_ff [0:QUO_W-1];
   logic [QUO_W-1:0] low_ff [0:QUO_W-1];
   logic [QUO_W-1:0] quo_ff [0:QUO_W-1];
   logic [DEN_W-1:0] den_ff [0:QUO_W-1];
   side_type side_ff [0:QUO_W-1];
   logic valid_ff [0:QUO_W-1];

   genvar i;
   generate
      for (i = 0; i < QUO_W; i++) begin : g_step
         logic [DEN_W-1:0] src_rem;
         logic [QUO_W-1:0] src_low;
         logic [QUO_W-1:0] src_quo;
         logic [DEN_W-1:0] src_den;
         side_type src_side;
         logic src_valid;
         logic [DEN_W:0] trial;
         logic ge;
         logic [DEN_W:0] diff;

         if (i == 0) begin : g_first
            // The quotient fits in QUO_W bits, so the top dividend bits lie below the divisor.
            assign src_rem = DEN_W'(in_num[NUM_W-1:QUO_W]);
            assign src_low = in_num[QUO_W-1:0];
            assign src_quo = '0;
            assign src_den = in_den;
            assign src_side = in_side;
            assign src_valid = in_valid;
         end else begin : g_next
            assign src_rem = rem_ff[i-1];
            assign src_low = low_ff[i-1];
            assign src_quo = quo_ff[i-1];
            assign src_den = den_ff[i-1];
            assign src_side = side_ff[i-1];
            assign src_valid = valid_ff[i-1];
         end

         assign trial = {src_rem, src_low[QUO_W-1]};
         assign ge = trial >= {1'b0, src_den};
         assign diff = trial - {1'b0, src_den};

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (en) begin
               valid_ff[i] <= src_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               low_ff[i] <= {src_low[QUO_W-2:0], 1'b0};
               quo_ff[i] <= {src_quo[QUO_W-2:0], ge};
               den_ff[i] <= src_den;
               side_ff[i] <= src_side;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo = quo_ff[QUO_W-1];
   assign out_side = side_ff[QUO_W-1];

endmodule

// ===== rtl/triangle_cell_coverage_area.sv =====
// Top level: triangle cell coverage pipeline with output register.
`timescale 1ns / 1ps
// One cell enters per clock while the pipeline is not frozen; its result passes through five stages of grid
// check, corner tests and the area numerator, 34 stages of the pipelined divider (one
// quotient bit each), and the output register. When rsp_stall holds a waiting beat, the
// whole pipeline freezes and req_stall rises in the same cycle; nothing is dropped.
module triangle_cell_coverage_area import tcca_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [LEN_W-1:0] req_base_left_length,
   input  logic [LEN_W-1:0] req_base_right_length,
   input  logic [LEN_W-1:0] req_tri_height,
   input  logic [LEN_W-1:0] req_cell_size,
   input  logic signed [COL_W-1:0] req_column,
   input  logic [ROW_W-1:0] req_row,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [AREA_W-1:0] rsp_covered_area,
   output logic [KIND_W-1:0] rsp_coverage_kind
);

   logic en;
   logic rsp_valid_ff;
   logic [AREA_W-1:0] rsp_area_ff;
   logic [KIND_W-1:0] rsp_kind_ff;

   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Stage 1: pick the edge side and place the cell.
   logic v1_ff;
   logic [15:0] len1_ff, h1_ff, d1_ff;
   logic [25:0] x1_ff;
   logic [26:0] y1_ff;
   logic [9:0] k_in;
   logic [15:0] len_in;

   always_comb begin
      if (!req_column[COL_W-1]) begin
         len_in = req_base_right_length;
         k_in = req_column[9:0];
      end else begin
         len_in = req_base_left_length;
         k_in = ~req_column[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len1_ff <= len_in;
         h1_ff <= req_tri_height;
         d1_ff <= req_cell_size;
         x1_ff <= k_in * req_cell_size;
         y1_ff <= req_row * req_cell_size;
      end
   end

   // Stage 2: grid check and the edge-line products.
   logic v2_ff, grid2_ff;
   logic [15:0] d2_ff, len2_ff, h2_ff;
   logic [31:0] hl2_ff, hxl2_ff, lyb2_ff, full2_ff, hd2_ff, ld2_ff;
   logic [32:0] hxr2_ff, lyt2_ff;
   logic [15:0] xl_w, yb_w;
   logic [16:0] xr_w, yt_w;

   assign xl_w = x1_ff[15:0];
   assign yb_w = y1_ff[15:0];
   assign xr_w = {1'b0, xl_w} + {1'b0, d1_ff};
   assign yt_w = {1'b0, yb_w} + {1'b0, d1_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         grid2_ff <= (x1_ff < 26'(len1_ff)) && (y1_ff < 27'(h1_ff)) && (d1_ff != '0)
                     && (len1_ff != '0) && (h1_ff != '0);
         d2_ff <= d1_ff;
         len2_ff <= len1_ff;
         h2_ff <= h1_ff;
         hl2_ff <= h1_ff * len1_ff;
         hxl2_ff <= h1_ff * xl_w;
         hxr2_ff <= h1_ff * xr_w;
         lyb2_ff <= len1_ff * yb_w;
         lyt2_ff <= len1_ff * yt_w;
         full2_ff <= d1_ff * d1_ff;
         hd2_ff <= h1_ff * d1_ff;
         ld2_ff <= len1_ff * d1_ff;
      end
   end

   // Stage 3: corner tests, case choice and division operands.
   logic v3_ff;
   side_type side3_ff;
   logic [33:0] mul_a3_ff;
   logic [31:0] mul_b3_ff, add3_ff;
   logic [DEN_W-1:0] den3_ff;
   logic [34:0] e_ll, e_lr, e_ul, e_ur, neg_ur, n_b, n_c;
   logic in_ll, in_lr, in_ul, in_ur;
   side_type side_in;
   logic [33:0] mul_a_in;
   logic [31:0] mul_b_in, add_in;
   logic [DEN_W-1:0] den_in;

   always_comb begin
      e_ll = 35'(hl2_ff) - 35'(hxl2_ff) - 35'(lyb2_ff);
      e_lr = 35'(hl2_ff) - 35'(hxr2_ff) - 35'(lyb2_ff);
      e_ul = 35'(hl2_ff) - 35'(hxl2_ff) - 35'(lyt2_ff);
      e_ur = 35'(hl2_ff) - 35'(hxr2_ff) - 35'(lyt2_ff);
      in_ll = !e_ll[34];
      in_lr = !e_lr[34];
      in_ul = !e_ul[34];
      in_ur = !e_ur[34];
      neg_ur = 35'd0 - e_ur;
      n_b = {e_lr[33:0], 1'b0} + 35'(hd2_ff);
      n_c = {e_ul[33:0], 1'b0} + 35'(ld2_ff);

      side_in.full = full2_ff;
      side_in.sub_mode = 1'b0;
      if (!grid2_ff || !in_ll) begin
         side_in.kind = KIND_EMPTY;
      end else if (in_ur) begin
         side_in.kind = KIND_FULL;
      end else begin
         side_in.kind = KIND_PARTIAL;
      end

      if (in_ul && in_lr) begin
         // Only the upper outer corner is cut off: divide out that small triangle.
         side_in.sub_mode = 1'b1;
         mul_a_in = neg_ur[33:0];
         mul_b_in = neg_ur[31:0];
         add_in = hl2_ff;
         den_in = {hl2_ff, 1'b0};
      end else if (in_lr) begin
         mul_a_in = n_b[33:0];
         mul_b_in = 32'(d2_ff);
         add_in = 32'(len2_ff);
         den_in = DEN_W'({len2_ff, 1'b0});
      end else if (in_ul) begin
         mul_a_in = n_c[33:0];
         mul_b_in = 32'(d2_ff);
         add_in = 32'(h2_ff);
         den_in = DEN_W'({h2_ff, 1'b0});
      end else begin
         mul_a_in = e_ll[33:0];
         mul_b_in = e_ll[31:0];
         add_in = hl2_ff;
         den_in = {hl2_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff <= side_in;
         mul_a3_ff <= mul_a_in;
         mul_b3_ff <= mul_b_in;
         add3_ff <= add_in;
         den3_ff <= den_in;
      end
   end

   // Stage 4: numerator product. Stage 5: rounding addend.
   logic v4_ff, v5_ff;
   side_type side4_ff, side5_ff;
   logic [NUM_W-1:0] prod4_ff, num5_ff;
   logic [31:0] add4_ff;
   logic [DEN_W-1:0] den4_ff, den5_ff;
   logic [65:0] prod_w;

   assign prod_w = mul_a3_ff * mul_b3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod4_ff <= prod_w[NUM_W-1:0];
         add4_ff <= add3_ff;
         den4_ff <= den3_ff;
         side4_ff <= side3_ff;
         num5_ff <= prod4_ff + NUM_W'(add4_ff);
         den5_ff <= den4_ff;
         side5_ff <= side4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   logic div_valid;
   logic [QUO_W-1:0] div_quo;
   side_type div_side;
   side_type div_side_src;

   assign div_side_src = side5_ff;

   tcca_div u_div (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(v5_ff),
      .in_num(num5_ff),
      .in_den(den5_ff),
      .in_side(div_side_src),
      .out_valid(div_valid),
      .out_quo(div_quo),
      .out_side(div_side)
   );

   // Final area: full cell, zero, clamped quotient, or full cell minus the cut-off corner.
   logic [AREA_W-1:0] area_in;

   always_comb begin
      case (div_side.kind)
         KIND_FULL: area_in = div_side.full;
         KIND_PARTIAL: begin
            if (div_side.sub_mode) begin
               area_in = (div_quo >= QUO_W'(div_side.full)) ? '0
                         : div_side.full - div_quo[AREA_W-1:0];
            end else begin
               area_in = (div_quo > QUO_W'(div_side.full)) ? div_side.full
                         : div_quo[AREA_W-1:0];
            end
         end
         default: area_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_area_ff <= area_in;
         rsp_kind_ff <= div_side.kind;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_covered_area = rsp_area_ff;
   assign rsp_coverage_kind = rsp_kind_ff;

endmodule
